>>> rtl/core/tpl_pkg.sv
// Types, constants and helper functions shared by the text pen layout block.
// No dependencies; every other file of the block but tpl_urem refers to this package by scope.

package tpl_pkg;

   // field widths
   localparam int CHAR_W     = 8;
   localparam int COORD_W    = 16;
   localparam int WIDTH_W    = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   // control characters
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_ORIGIN_X      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ORIGIN_Y      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPACE_ADVANCE = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LINE_HEIGHT   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_DRAW_COLOR    = 3'd4;

   // register reset values
   localparam logic [7:0] SPACE_ADVANCE_RST = 8'd8;
   localparam logic [7:0] LINE_HEIGHT_RST   = 8'd8;

   // input item
   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              glyph_found;
      logic [7:0]        glyph_advance;
      logic              is_last;
   } req_type;

   // result item
   typedef struct packed {
      logic                      draw_enable;
      logic [CHAR_W-1:0]         glyph_code;
      logic signed [COORD_W-1:0] draw_x;
      logic signed [COORD_W-1:0] draw_y;
      logic                      string_done;
      logic [WIDTH_W-1:0]        text_width;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic latch_req;
      logic div_start;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_div;
      logic div_done;
   } stat_type;

   // clamp a widened signed sum to the 16-bit signed range
   function automatic logic signed [COORD_W-1:0] sat_s16(input logic signed [COORD_W+1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   // clamp a widened unsigned sum at 65535
   function automatic logic [WIDTH_W-1:0] sat_u16(input logic [WIDTH_W:0] v);
      logic [WIDTH_W-1:0] r;
      r = v[WIDTH_W] ? {WIDTH_W{1'b1}} : v[WIDTH_W-1:0];
      return r;
   endfunction

endpackage

>>> rtl/core/tpl_urem.sv
// Iterative unsigned remainder unit, one quotient bit per cycle (restoring).
// Standalone; used by tpl_datapath for the tab stop distance.

module tpl_urem #(
   parameter int DW = 16,
   parameter int VW = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [VW-1:0] remainder
);

   localparam int CNT_W = $clog2(DW + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DW-1:0]    dvd_ff;
   logic [VW-1:0]    dsr_ff;
   logic [VW-1:0]    rem_ff;

   logic [VW:0]      trial;
   logic [VW:0]      diff;
   logic             fits;
   logic             last_step;

   // shift in the next dividend bit and try the subtract
   assign trial     = {rem_ff, dvd_ff[DW-1]};
   assign diff      = trial - {1'b0, dsr_ff};
   assign fits      = trial >= {1'b0, dsr_ff};
   assign last_step = cnt_ff == CNT_W'(DW - 1);

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last_step) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // operands and partial remainder
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DW-2:0], 1'b0};
         rem_ff <= fits ? diff[VW-1:0] : trial[VW-1:0];
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/core/tpl_datapath.sv
// Datapath of the text pen layout: configuration registers, pen and width state,
// the tab remainder unit and the result register. Depends on tpl_pkg and tpl_urem.

module tpl_datapath #(
   parameter int TAB_COLUMNS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [tpl_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [tpl_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  tpl_pkg::req_type               req_data,
   input  tpl_pkg::cmd_type               cmd,
   output tpl_pkg::stat_type              stat,
   output tpl_pkg::rsp_type               rsp_data
);

   localparam int TW_W = 8 + $clog2(TAB_COLUMNS + 1);
   localparam int CW   = tpl_pkg::COORD_W;
   localparam int WW   = tpl_pkg::WIDTH_W;

   // configuration
   logic signed [CW-1:0] origin_x_ff;
   logic signed [CW-1:0] origin_y_ff;
   logic [7:0]           space_adv_ff;
   logic [7:0]           line_height_ff;

   // layout state
   logic                 in_string_ff;
   logic signed [CW-1:0] pen_x_ff;
   logic signed [CW-1:0] pen_y_ff;
   logic [WW-1:0]        row_len_ff;
   logic [WW-1:0]        widest_ff;

   tpl_pkg::req_type     item_ff;
   tpl_pkg::rsp_type     rsp_ff;
   tpl_pkg::rsp_type     rsp_in;

   logic signed [CW-1:0] cur_x;
   logic signed [CW-1:0] cur_y;
   logic [WW-1:0]        cur_lw;
   logic [WW-1:0]        cur_wide;
   logic [WW-1:0]        closed_wide;

   logic [TW_W-1:0]      stop_span;
   logic [TW_W-1:0]      tab_rem;
   logic [TW_W-1:0]      tab_step;
   logic [TW_W-1:0]      add_amt;
   logic                 is_tab;
   logic                 div_done;

   logic signed [CW+1:0] x_sum;
   logic signed [CW+1:0] y_sum;
   logic [WW:0]          lw_sum;

   logic signed [CW-1:0] pen_x_in;
   logic signed [CW-1:0] pen_y_in;
   logic [WW-1:0]        row_len_in;
   logic [WW-1:0]        widest_in;
   logic                 draw;

   // register writes; the draw color index is accepted but not stored here
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         space_adv_ff   <= tpl_pkg::SPACE_ADVANCE_RST;
         line_height_ff <= tpl_pkg::LINE_HEIGHT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            tpl_pkg::CSR_ORIGIN_X:      origin_x_ff    <= csr_wdata;
            tpl_pkg::CSR_ORIGIN_Y:      origin_y_ff    <= csr_wdata;
            tpl_pkg::CSR_SPACE_ADVANCE: space_adv_ff   <= csr_wdata[7:0];
            tpl_pkg::CSR_LINE_HEIGHT:   line_height_ff <= csr_wdata[7:0];
            tpl_pkg::CSR_DRAW_COLOR: begin
            end
            default: begin
            end
         endcase
      end
   end

   // item capture on an input transfer
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         item_ff <= req_data;
      end
   end

   // a string starts from the origin
   assign cur_x    = in_string_ff ? pen_x_ff : origin_x_ff;
   assign cur_y    = in_string_ff ? pen_y_ff : origin_y_ff;
   assign cur_lw   = in_string_ff ? row_len_ff : '0;
   assign cur_wide = in_string_ff ? widest_ff : '0;
   assign closed_wide = (cur_lw > cur_wide) ? cur_lw : cur_wide;

   // tab stop spacing and remainder of the line width
   assign stop_span = TW_W'(space_adv_ff) * TW_W'(TAB_COLUMNS);
   assign is_tab    = item_ff.char_code == tpl_pkg::CH_TAB;

   tpl_urem #(
      .DW (WW),
      .VW (TW_W)
   ) u_urem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (cur_lw),
      .divisor   (stop_span),
      .done      (div_done),
      .remainder (tab_rem)
   );

   assign tab_step = (stop_span == '0) ? '0 : stop_span - tab_rem;

   assign stat.need_div = is_tab && (stop_span != '0);
   assign stat.div_done = div_done;

   // tab steps and glyph advances share the pen x and line width adders
   assign add_amt = is_tab ? tab_step : TW_W'(item_ff.glyph_advance);
   assign x_sum   = (CW+2)'(cur_x) + (CW+2)'(add_amt);
   assign lw_sum  = (WW+1)'(cur_lw) + (WW+1)'(add_amt);
   assign y_sum   = (CW+2)'(cur_y) + (CW+2)'(line_height_ff);

   // next layout state
   always_comb begin
      pen_x_in   = cur_x;
      pen_y_in   = cur_y;
      row_len_in = cur_lw;
      widest_in  = cur_wide;
      draw       = 1'b0;
      case (item_ff.char_code)
         tpl_pkg::CH_NEWLINE: begin
            widest_in  = closed_wide;
            row_len_in = '0;
            pen_x_in   = origin_x_ff;
            pen_y_in   = tpl_pkg::sat_s16(y_sum);
         end
         tpl_pkg::CH_RETURN: begin
            widest_in  = closed_wide;
            row_len_in = '0;
            pen_x_in   = origin_x_ff;
         end
         tpl_pkg::CH_TAB: begin
            pen_x_in   = tpl_pkg::sat_s16(x_sum);
            row_len_in = tpl_pkg::sat_u16(lw_sum);
         end
         default: begin
            if (item_ff.glyph_found) begin
               draw       = 1'b1;
               pen_x_in   = tpl_pkg::sat_s16(x_sum);
               row_len_in = tpl_pkg::sat_u16(lw_sum);
            end
         end
      endcase
   end

   // result fields
   always_comb begin
      rsp_in.draw_enable = draw;
      rsp_in.glyph_code  = draw ? item_ff.char_code : '0;
      rsp_in.draw_x      = draw ? cur_x : '0;
      rsp_in.draw_y      = draw ? cur_y : '0;
      rsp_in.string_done = item_ff.is_last;
      rsp_in.text_width  = (row_len_in > widest_in) ? row_len_in : widest_in;
   end

   // string-open flag; a last item sends the next string back to the origin
   always_ff @(posedge clock) begin
      if (reset) begin
         in_string_ff <= 1'b0;
      end else if (cmd.commit) begin
         in_string_ff <= !item_ff.is_last;
      end
   end

   // layout state and result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         pen_x_ff   <= pen_x_in;
         pen_y_ff   <= pen_y_in;
         row_len_ff <= row_len_in;
         widest_ff  <= widest_in;
         rsp_ff     <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> rtl/core/tpl_ctrl.sv
// Controller of the text pen layout: sequences capture, tab remainder and commit,
// and owns both handshakes. Depends on tpl_pkg.

module tpl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  tpl_pkg::stat_type stat,
   output tpl_pkg::cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DECODE = 2'd1;
   localparam logic [1:0] ST_DIV    = 2'd2;
   localparam logic [1:0] ST_EXEC   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign req_ready = state_ff == ST_IDLE;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // commands
   assign cmd.latch_req = req_valid && req_ready;
   assign cmd.div_start = (state_ff == ST_DECODE) && stat.need_div;
   assign cmd.commit    = (state_ff == ST_EXEC) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = stat.need_div ? ST_DIV : ST_EXEC;
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output slot occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/core/text_pen_layout_with_tab_stops.sv
// Text pen layout with tab stops: one character in, one draw/status result out.
// Each item passes the idle, decode and exec states; a tab with a nonzero stop spacing
// also passes the div state for the bit-serial remainder (one bit per cycle over 16 bits).
// A new item is taken only once the last one is committed, while its result may
// still wait in the output register. Reset is synchronous, active high:
// it restores register defaults and puts the pen at the origin for the next string.

module text_pen_layout_with_tab_stops #(
   parameter int TAB_COLUMNS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  tpl_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output tpl_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [tpl_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [tpl_pkg::CSR_DATA_W-1:0] csr_wdata
);

   tpl_pkg::cmd_type  cmd;
   tpl_pkg::stat_type stat;

   // sequencing and handshakes
   tpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // registers, layout state and result
   tpl_datapath #(
      .TAB_COLUMNS (TAB_COLUMNS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/core/tpl_checker.sv
// Port-level checks for the text pen layout block, attached by bind.
// Depends on tpl_pkg and the top level text_pen_layout_with_tab_stops.

module tpl_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tpl_pkg::rsp_type rsp_data
);

   // no result straight out of reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // no draw means zero glyph and position
   a_no_draw_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.draw_enable |->
         rsp_data.glyph_code == '0 && rsp_data.draw_x == '0 && rsp_data.draw_y == '0)
      else $error("non-draw result carries glyph data");

   // newline, return and tab never draw
   a_ctrl_no_draw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.draw_enable |->
         rsp_data.glyph_code != tpl_pkg::CH_NEWLINE &&
         rsp_data.glyph_code != tpl_pkg::CH_RETURN &&
         rsp_data.glyph_code != tpl_pkg::CH_TAB)
      else $error("control character drawn");

endmodule

bind text_pen_layout_with_tab_stops tpl_checker u_tpl_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> tb/pen_layout_checker.sv
`timescale 1ns / 100ps
// Checker for the text pen layout block: follows register writes, predicts each result
// from the accepted characters and compares it field by field. Depends on tpl_pkg.

module pen_layout_checker #(
   parameter int TAB_COLUMNS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  tpl_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  tpl_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [tpl_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [tpl_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending_count
);
   import tpl_pkg::*;

   // register copies
   int org_x, org_y, space_adv, line_step;
   // pen state
   int pen_x, pen_y, row_len, widest_line;
   bit in_string;

   rsp_type predicted_layout[$];
   int mismatches = 0;

   assign fail_count = mismatches;

   function automatic int clamp_coord(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic int clamp_width(int v);
      return (v > 65535) ? 65535 : v;
   endfunction

   function automatic void close_line();
      if (row_len > widest_line) begin
         widest_line = row_len;
      end
      row_len = 0;
   endfunction

   function automatic void pen_home();
      pen_x = org_x;
      pen_y = org_y;
      row_len = 0;
      widest_line = 0;
   endfunction

   // lay out one character and build the result it produces
   function automatic rsp_type place_char(req_type item);
      rsp_type r;
      int stop_gap;
      int step;
      r = '0;
      if (!in_string) begin
         pen_home();
         in_string = 1'b1;
      end
      if (item.char_code == CH_NEWLINE) begin
         close_line();
         pen_x = org_x;
         pen_y = clamp_coord(pen_y + line_step);
      end else if (item.char_code == CH_RETURN) begin
         close_line();
         pen_x = org_x;
      end else if (item.char_code == CH_TAB) begin
         // jump to the next stop counted from the line start
         stop_gap = space_adv * TAB_COLUMNS;
         step = (stop_gap != 0) ? stop_gap - (row_len % stop_gap) : 0;
         pen_x = clamp_coord(pen_x + step);
         row_len = clamp_width(row_len + step);
      end else if (item.glyph_found) begin
         r.draw_enable = 1'b1;
         r.glyph_code = item.char_code;
         r.draw_x = 16'(pen_x);
         r.draw_y = 16'(pen_y);
         pen_x = clamp_coord(pen_x + int'(item.glyph_advance));
         row_len = clamp_width(row_len + int'(item.glyph_advance));
      end
      r.string_done = item.is_last;
      r.text_width = 16'((row_len > widest_line) ? row_len : widest_line);
      if (item.is_last) begin
         pen_home();
         in_string = 1'b0;
      end
      return r;
   endfunction

   task automatic log_failure(string what);
      if (mismatches < 10) begin
         $display("%0t: %s", $realtime, what);
      end
      mismatches++;
   endtask

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         log_failure($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         org_x = 0;
         org_y = 0;
         space_adv = SPACE_ADVANCE_RST;
         line_step = LINE_HEIGHT_RST;
         pen_home();
         in_string = 1'b0;
         predicted_layout.delete();
      end else begin
         // register writes, out-of-range indexes are dropped
         if (csr_we) begin
            case (csr_addr)
               CSR_ORIGIN_X:      org_x = int'($signed(csr_wdata));
               CSR_ORIGIN_Y:      org_y = int'($signed(csr_wdata));
               CSR_SPACE_ADVANCE: space_adv = int'(csr_wdata[7:0]);
               CSR_LINE_HEIGHT:   line_step = int'(csr_wdata[7:0]);
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predicted_layout.push_back(place_char(req_data));
         end
         // result transfer against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (predicted_layout.size() == 0) begin
               log_failure("result with no character outstanding");
            end else begin
               want = predicted_layout.pop_front();
               check_field("draw_enable", 16'(want.draw_enable), 16'(rsp_data.draw_enable));
               check_field("glyph_code", 16'(want.glyph_code), 16'(rsp_data.glyph_code));
               check_field("draw_x", want.draw_x, rsp_data.draw_x);
               check_field("draw_y", want.draw_y, rsp_data.draw_y);
               check_field("string_done", 16'(want.string_done), 16'(rsp_data.string_done));
               check_field("text_width", want.text_width, rsp_data.text_width);
            end
         end
      end
      pending_count <= predicted_layout.size();
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the text pen layout testbench: clock, reset, register setup and character
// stimulus under several idling modes. Depends on tpl_pkg, the DUT and pen_layout_checker.

module tb_top;
   import tpl_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending_count;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int chars_left = 0;
   bit wide_line = 1'b0;

   text_pen_layout_with_tab_stops dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   pen_layout_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always #1 clock = ~clock;

   // result side back-pressure
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   function automatic req_type char_item(logic [7:0] ch, logic found, logic [7:0] adv,
                                         logic last);
      req_type item;
      item.char_code = ch;
      item.glyph_found = found;
      item.glyph_advance = adv;
      item.is_last = last;
      return item;
   endfunction

   // one input transfer, with random idle cycles in front
   task automatic send(req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all(int ox, int oy, int adv, int step, int color);
      csr_write(CSR_ORIGIN_X, 16'(ox));
      csr_write(CSR_ORIGIN_Y, 16'(oy));
      csr_write(CSR_SPACE_ADVANCE, 16'(adv));
      csr_write(CSR_LINE_HEIGHT, 16'(step));
      csr_write(CSR_DRAW_COLOR, 16'(color));
      // index past the register file, must be dropped
      csr_write(3'(CSR_DRAW_COLOR + 1 + $urandom_range(2)), 16'($urandom));
   endtask

   function automatic int pick_coord();
      case ($urandom_range(5))
         0: return 32767;
         1: return -32768;
         default: return int'($urandom_range(400)) - 200;
      endcase
   endfunction

   function automatic int pick_unit();
      case ($urandom_range(5))
         0: return 0;
         1: return 255;
         default: return int'($urandom_range(1, 12));
      endcase
   endfunction

   task automatic load_phase_config(int phase);
      case (phase)
         1: write_all(-32768, 32767, 255, 255, 255);
         2: write_all(32767, -32768, 0, 0, 0);
         5: write_all(pick_coord(), pick_coord(), 255, pick_unit(), $urandom_range(255));
         default: write_all(pick_coord(), pick_coord(), pick_unit(), pick_unit(),
                            $urandom_range(255));
      endcase
   endtask

   // next character of a random string; strings run across phase boundaries
   task automatic send_random_char();
      int roll;
      logic [7:0] ch;
      logic found;
      logic [7:0] adv;
      logic last;
      if (chars_left == 0) begin
         wide_line = ($urandom_range(9) == 0);
         chars_left = wide_line ? $urandom_range(40, 70) : $urandom_range(1, 24);
      end
      roll = $urandom_range(99);
      ch = 8'($urandom_range(CH_SPACE + 1, 8'h7E));
      found = 1'b1;
      adv = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(16));
      last = (chars_left == 1);
      if (wide_line) begin
         // long lines drive the width and pen into saturation
         if (roll < 70) begin
            ch = CH_TAB;
         end else begin
            adv = 8'hFF;
         end
      end else if (roll < 8) begin
         ch = CH_NEWLINE;
      end else if (roll < 14) begin
         ch = CH_RETURN;
      end else if (roll < 24) begin
         ch = CH_TAB;
      end else if (roll < 32) begin
         found = 1'b0;
         ch = 8'($urandom_range(255));
      end else if (roll < 38) begin
         // noise: any byte, any flags, possibly an early end of string
         ch = 8'($urandom_range(255));
         found = 1'($urandom_range(1));
         adv = 8'($urandom_range(255));
         last = last || ($urandom_range(3) == 0);
      end
      send(char_item(ch, found, adv, last));
      chars_left = last ? 0 : chars_left - 1;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed string at reset settings
      send_idle_pct = 14;
      stall_pct = 14;
      send(char_item("A", 1'b1, 8'd0, 1'b0));
      send(char_item("B", 1'b1, 8'd255, 1'b0));
      send(char_item(CH_TAB, 1'b1, 8'd9, 1'b0));
      send(char_item("C", 1'b0, 8'd40, 1'b0));
      send(char_item(CH_RETURN, 1'b1, 8'd5, 1'b0));
      send(char_item("D", 1'b1, 8'd7, 1'b0));
      send(char_item(CH_NEWLINE, 1'b1, 8'd3, 1'b0));
      send(char_item(CH_TAB, 1'b0, 8'd0, 1'b0));
      send(char_item(8'hFF, 1'b1, 8'd255, 1'b0));
      send(char_item(8'h00, 1'b1, 8'd128, 1'b1));
      send(char_item(CH_SPACE, 1'b0, 8'd1, 1'b1));

      // origin at the top corner, zero tab width
      wait_idle();
      write_all(32767, 32767, 0, 255, 255);
      send(char_item("x", 1'b1, 8'd255, 1'b0));
      send(char_item("x", 1'b1, 8'd255, 1'b0));
      send(char_item(CH_TAB, 1'b1, 8'd1, 1'b0));
      send(char_item(CH_NEWLINE, 1'b0, 8'd0, 1'b0));
      send(char_item(CH_RETURN, 1'b0, 8'd0, 1'b0));
      send(char_item("y", 1'b1, 8'd1, 1'b0));

      // new origin written in the middle of a string
      wait_idle();
      write_all(-32768, -32768, 255, 0, 0);
      send(char_item(CH_TAB, 1'b0, 8'd0, 1'b0));
      send(char_item("z", 1'b1, 8'd200, 1'b0));
      send(char_item(CH_RETURN, 1'b0, 8'd0, 1'b0));
      send(char_item("q", 1'b1, 8'd3, 1'b1));

      // random strings, each phase with its own settings and idling mode
      for (int phase = 0; phase < 8; phase++) begin
         wait_idle();
         load_phase_config(phase);
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 76; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 76; end
            default: begin send_idle_pct = 14; stall_pct = 14; end
         endcase
         repeat (116) send_random_char();
      end

      wait_idle();
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // run limit
   initial begin
      #1_500_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
